>>> hw/rtl/dwmf_pkg.sv
package dwmf_pkg;

  localparam int DEPTH_W      = 16;
  localparam int ROW_W        = 12;
  localparam int FW_W         = 10;
  localparam int MIN_COUNT_W  = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int HEIGHT_LIMIT = 4095;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_DEPTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT      = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [FW_W-1:0]        RST_FRAME_WIDTH    = 10'd512;
  localparam logic [ROW_W-1:0]       RST_FRAME_HEIGHT   = 12'd424;
  localparam logic [DEPTH_W-1:0]     RST_DEPTH_TOL      = 16'd50;
  localparam logic [DEPTH_W-1:0]     RST_FALLBACK_DEPTH = 16'd4500;
  localparam logic [MIN_COUNT_W-1:0] RST_MIN_COUNT      = 4'd4;

  typedef struct packed {
    logic               op;
    logic [DEPTH_W-1:0] depth_mm;
  } dwmf_in_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] filtered_depth;
    logic               frame_last;
  } dwmf_out_t;

  typedef struct packed {
    logic [FW_W-1:0]        frame_width;
    logic [ROW_W-1:0]       frame_height;
    logic [DEPTH_W-1:0]     depth_tol;
    logic [DEPTH_W-1:0]     fallback_depth;
    logic [MIN_COUNT_W-1:0] min_count;
  } dwmf_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CTR,
    ST_SCAN,
    ST_LAST,
    ST_DEC,
    ST_DIVW,
    ST_OUT
  } dwmf_state_t;

endpackage

>>> hw/rtl/dwmf_line_store.sv
module dwmf_line_store #(
  parameter int ROWS = 3,
  parameter int COLS = 512
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(ROWS)-1:0]     wr_row,
  input  logic [$clog2(COLS)-1:0]     wr_col,
  input  logic [dwmf_pkg::DEPTH_W-1:0] wr_data,
  input  logic [$clog2(ROWS)-1:0]     rd_row,
  input  logic [$clog2(COLS)-1:0]     rd_col,
  output logic [dwmf_pkg::DEPTH_W-1:0] rd_data
);
  import dwmf_pkg::*;

  logic [DEPTH_W-1:0] mem [ROWS][COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_row][rd_col];
  end

endmodule

>>> hw/rtl/dwmf_div.sv
module dwmf_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DIVIDEND_W-1:0]        dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic [dwmf_pkg::DEPTH_W-1:0] quotient
);
  import dwmf_pkg::*;

  localparam int STEP_W = $clog2(DEPTH_W);

  logic [DIVIDEND_W-1:0] rem_r;
  logic [DIVIDEND_W-1:0] dsr_r;
  logic [DEPTH_W-1:0]    q_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic                  done_r;
  logic                  ge;

  assign ge       = rem_r >= dsr_r;
  assign done     = done_r;
  assign quotient = q_r;

  // restoring division, one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DEPTH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsr_r <= DIVIDEND_W'(divisor) << (DEPTH_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      q_r   <= {q_r[DEPTH_W-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/depth_window_mean_filter_unit.sv
// Depth window mean filter.
// Input channel in_valid/in_ready/in_data carries depth pixels in raster order
// (op = pixel) or flush ticks (op = flush). Result channel out_valid/out_ready/
// out_data gives the filtered depth of a window centre and a frame_last flag.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes frame geometry
// and filter registers, always ready; user writes only while idle, unenforced.
// The result for centre index c follows the pixel with index c + RADIUS*W +
// RADIUS; flush ticks after the last pixel of a frame drain the rest.
// A pixel with no result does not hold the input. A pixel or flush that yields
// a result holds the input while the window is scanned and then the mean is
// formed, or the fallback depth is used when at most min_count samples match;
// out_valid rises at the edge that frees the input. The window is read one
// sample a cycle from the line store, then a 16-step serial divider forms the mean.
// One item is in progress at a time.
// A finished result waits in the output register; input is taken while it is
// full, but a stalled receiver holds back the next result and then the input.
// Synchronous reset clears the positions and loads the register defaults;
// the line store contents are not cleared.
module depth_window_mean_filter_unit #(
  parameter int MAX_WIDTH = 512,
  parameter int RADIUS    = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dwmf_pkg::dwmf_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dwmf_pkg::dwmf_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dwmf_pkg::*;

  localparam int WIN   = 2 * RADIUS + 1;
  localparam int NWIN  = WIN * WIN;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int LW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = (LW > FW_W) ? LW : FW_W;
  localparam int SW    = $clog2(WIN);
  localparam int CNTW  = $clog2(NWIN + 1);
  localparam int SUMW  = DEPTH_W + CNTW;
  localparam int MCW   = (CNTW > MIN_COUNT_W) ? CNTW : MIN_COUNT_W;
  localparam int YW    = ROW_W + 1;
  localparam int XSW   = LW + 1;

  dwmf_state_t state_r, state_nxt;
  dwmf_cfg_t   cfg_r;

  logic [LW-1:0]    lat_w_r;
  logic [ROW_W-1:0] lat_h_r;
  logic [XW-1:0]    in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [SW-1:0]    in_slot_r;
  logic [XW-1:0]    out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic [SW-1:0]    out_slot_r;
  logic [SW-1:0]    ky_r, kx_r, scan_slot_r;
  logic             rd_pend_r, ctr_pend_r;
  logic             out_valid_r;
  dwmf_out_t        out_data_r;

  logic [DEPTH_W-1:0] centre_r;
  logic [SUMW-1:0]    sum_r;
  logic [CNTW-1:0]    cnt_r;
  logic [DEPTH_W-1:0] result_r;

  logic               in_fire;
  logic               draining;
  logic               at_start;
  logic               emit_now;
  logic [LW-1:0]      w_clamp;
  logic [ROW_W-1:0]   h_clamp;
  logic [LW-1:0]      w_eff;
  logic               col_wrap;
  logic               out_last;
  logic               mem_we;
  logic [SW-1:0]      rd_slot;
  logic [XW-1:0]      rd_col;
  logic [DEPTH_W-1:0] rd_data;
  logic [YW-1:0]      ysum;
  logic [XSW-1:0]     xsum;
  logic               y_ok, x_ok;
  logic [XW-1:0]      x_col;
  logic               scan_end;
  logic [SW:0]        slot_base;
  logic [SW-1:0]      slot_init;
  logic [DEPTH_W-1:0] diff;
  logic               hit;
  logic               qualifies;
  logic               div_start;
  logic               div_done;
  logic [DEPTH_W-1:0] div_q;
  logic               out_load;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // geometry clamp applied when a frame starts
  always_comb begin
    if (CMPW'(cfg_r.frame_width) < CMPW'(WIN)) begin
      w_clamp = LW'(WIN);
    end else if (CMPW'(cfg_r.frame_width) > CMPW'(MAX_WIDTH)) begin
      w_clamp = LW'(MAX_WIDTH);
    end else begin
      w_clamp = LW'(cfg_r.frame_width);
    end
    if (cfg_r.frame_height < ROW_W'(WIN)) begin
      h_clamp = ROW_W'(WIN);
    end else begin
      h_clamp = cfg_r.frame_height;
    end
  end

  assign draining = in_row_r >= lat_h_r;
  assign at_start = (in_row_r == '0) && (in_col_r == '0);
  assign w_eff    = at_start ? w_clamp : lat_w_r;
  assign col_wrap = (XSW'(in_col_r) + XSW'(1)) >= XSW'(w_eff);
  assign emit_now = (in_row_r > ROW_W'(RADIUS)) ||
                    ((in_row_r == ROW_W'(RADIUS)) && (XSW'(in_col_r) >= XSW'(RADIUS)));
  assign out_last = (out_row_r == lat_h_r - ROW_W'(1)) &&
                    ((XSW'(out_col_r) + XSW'(1)) == XSW'(lat_w_r));

  // window sample position
  assign ysum     = YW'(out_row_r) + YW'(ky_r);
  assign y_ok     = (ysum >= YW'(RADIUS)) && (ysum < YW'(lat_h_r) + YW'(RADIUS));
  assign xsum     = XSW'(out_col_r) + XSW'(kx_r);
  assign x_ok     = (xsum >= XSW'(RADIUS)) && (xsum < XSW'(lat_w_r) + XSW'(RADIUS));
  assign x_col    = XW'(xsum - XSW'(RADIUS));
  assign scan_end = (ky_r == SW'(2 * RADIUS)) && (kx_r == SW'(2 * RADIUS));

  // store row of the top window row
  assign slot_base = (SW + 1)'(out_slot_r) + (SW + 1)'(WIN - RADIUS);
  assign slot_init = (slot_base >= (SW + 1)'(WIN)) ? SW'(slot_base - (SW + 1)'(WIN))
                                                   : SW'(slot_base);

  assign diff      = (rd_data > centre_r) ? rd_data - centre_r : centre_r - rd_data;
  assign hit       = (rd_data != '0) && (diff < cfg_r.depth_tol);
  assign qualifies = MCW'(cnt_r) > MCW'(cfg_r.min_count);

  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    rd_slot   = scan_slot_r;
    rd_col    = x_col;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_FLUSH) begin
            if (draining) begin
              state_nxt = ST_CTR;
            end
          end else if (!draining) begin
            mem_we = 1'b1;
            if (emit_now) begin
              state_nxt = ST_CTR;
            end
          end
        end
      end
      ST_CTR: begin
        rd_slot   = out_slot_r;
        rd_col    = out_col_r;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (qualifies) begin
          div_start = 1'b1;
          state_nxt = ST_DIVW;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= RST_FRAME_WIDTH;
      cfg_r.frame_height   <= RST_FRAME_HEIGHT;
      cfg_r.depth_tol      <= RST_DEPTH_TOL;
      cfg_r.fallback_depth <= RST_FALLBACK_DEPTH;
      cfg_r.min_count      <= RST_MIN_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    cfg_r.frame_width    <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT:   cfg_r.frame_height   <= cfg_data[ROW_W-1:0];
        CFG_DEPTH_TOL:      cfg_r.depth_tol      <= cfg_data[DEPTH_W-1:0];
        CFG_FALLBACK_DEPTH: cfg_r.fallback_depth <= cfg_data[DEPTH_W-1:0];
        CFG_MIN_COUNT:      cfg_r.min_count      <= cfg_data[MIN_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster positions, geometry and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_w_r     <= (CMPW'(RST_FRAME_WIDTH) > CMPW'(MAX_WIDTH)) ? LW'(MAX_WIDTH)
                                                                  : LW'(RST_FRAME_WIDTH);
      lat_h_r     <= RST_FRAME_HEIGHT;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      ky_r        <= '0;
      kx_r        <= '0;
      scan_slot_r <= '0;
      rd_pend_r   <= 1'b0;
      ctr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mem_we) begin
        if (at_start) begin
          lat_w_r <= w_clamp;
          lat_h_r <= h_clamp;
        end
        if (col_wrap) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + ROW_W'(1);
          in_slot_r <= (in_slot_r == SW'(WIN - 1)) ? '0 : in_slot_r + SW'(1);
        end else begin
          in_col_r <= in_col_r + XW'(1);
        end
      end

      ctr_pend_r <= (state_r == ST_CTR);
      case (state_r)
        ST_CTR: begin
          ky_r        <= '0;
          kx_r        <= '0;
          scan_slot_r <= slot_init;
          rd_pend_r   <= 1'b0;
        end
        ST_SCAN: begin
          rd_pend_r <= y_ok && x_ok;
          if (kx_r == SW'(2 * RADIUS)) begin
            kx_r        <= '0;
            ky_r        <= ky_r + SW'(1);
            scan_slot_r <= (scan_slot_r == SW'(WIN - 1)) ? '0 : scan_slot_r + SW'(1);
          end else begin
            kx_r <= kx_r + SW'(1);
          end
        end
        default: begin
          rd_pend_r <= 1'b0;
        end
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        if (out_last) begin
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_slot_r <= '0;
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_slot_r  <= '0;
        end else if ((XSW'(out_col_r) + XSW'(1)) == XSW'(lat_w_r)) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + ROW_W'(1);
          out_slot_r <= (out_slot_r == SW'(WIN - 1)) ? '0 : out_slot_r + SW'(1);
        end else begin
          out_col_r <= out_col_r + XW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window accumulation and result
  always_ff @(posedge clk) begin
    if (ctr_pend_r) begin
      centre_r <= rd_data;
    end
    if (state_r == ST_CTR) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (rd_pend_r && hit) begin
      sum_r <= sum_r + SUMW'(rd_data);
      cnt_r <= cnt_r + CNTW'(1);
    end
    if ((state_r == ST_DEC) && !qualifies) begin
      result_r <= cfg_r.fallback_depth;
    end else if (div_done) begin
      result_r <= div_q;
    end
    if (out_load) begin
      out_data_r.filtered_depth <= result_r;
      out_data_r.frame_last     <= out_last;
    end
  end

  dwmf_line_store #(
    .ROWS (WIN),
    .COLS (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_row  (in_slot_r),
    .wr_col  (in_col_r),
    .wr_data (in_data.depth_mm),
    .rd_row  (rd_slot),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  dwmf_div #(
    .DIVIDEND_W (SUMW),
    .DIVISOR_W  (CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef SYNTHESIS
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    XSW'(in_col_r) < XSW'(lat_w_r))
    else $error("input column beyond frame width");

  a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r <= in_row_r)
    else $error("result row ahead of input row");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW))
    else $error("divider finished outside its wait state");
`endif

endmodule
